// File: hdl/tte_pkg.sv
`default_nettype none
package tte_pkg;

    localparam int MODE_W    = 2;
    localparam int LEAF_W    = 10;
    localparam int VALUE_W   = 16;
    localparam int THR_W     = 6;
    localparam int LOW_W     = 6;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET  = 6'd32;
    localparam logic [VALUE_W-1:0] VALUE_NONE = 16'hFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CODE  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PATH,
        ST_SET_RD,
        ST_SET_CMP,
        ST_CODE_RD,
        ST_CODE_LD,
        ST_CODE_RUN,
        ST_CODE_WR,
        ST_FLUSH
    } t_state;

    // One tree node as stored in the node memory.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LOW_W-1:0]   low;
        logic               known;
    } t_node;

    typedef struct packed {
        logic accept;
        logic clr_start;
        logic clr_step;
        logic div_start;
        logic div_step;
        logic path_start;
        logic path_step;
        logic set_begin;
        logic set_wr;
        logic lvl_up;
        logic code_begin;
        logic code_ld;
        logic code_run;
        logic code_wr;
        logic lvl_dn;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic in_range;
        logic path_done;
        logic is_code;
        logic set_stop;
        logic lvl_top;
        logic lvl_zero;
        logic run_done;
        logic flush_done;
    } t_sts;

    // Total number of nodes over all levels of a full grid.
    function automatic int tte_node_cap(int across, int down);
        int w;
        int h;
        int total;
        w = across;
        h = down;
        total = 0;
        for (int k = 0; k < 8; k++) begin
            total = total + w * h;
            if (w * h <= 1) begin
                break;
            end
            w = (w + 1) / 2;
            h = (h + 1) / 2;
        end
        return total;
    endfunction

    // Number of levels from leaf to root of a full grid.
    function automatic int tte_levels(int across, int down);
        int w;
        int h;
        int lev;
        w = across;
        h = down;
        lev = 0;
        for (int k = 0; k < 8; k++) begin
            lev = lev + 1;
            if (w * h <= 1) begin
                break;
            end
            w = (w + 1) / 2;
            h = (h + 1) / 2;
        end
        return lev;
    endfunction

endpackage
`default_nettype wire

// File: hdl/tte_in_if.sv
`default_nettype none
interface tte_in_if;
    import tte_pkg::*;
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [LEAF_W-1:0]  leaf_index;
    logic [VALUE_W-1:0] leaf_value;
    logic [THR_W-1:0]   threshold;

    modport source(output valid, mode, leaf_index, leaf_value, threshold, input ready);
    modport sink(input valid, mode, leaf_index, leaf_value, threshold, output ready);
endinterface
`default_nettype wire

// File: hdl/tte_out_if.sv
`default_nettype none
interface tte_out_if;
    logic valid;
    logic ready;
    logic code_bit;
    logic last;

    modport source(output valid, code_bit, last, input ready);
    modport sink(input valid, code_bit, last, output ready);
endinterface
`default_nettype wire

// File: hdl/tte_ram.sv
`default_nettype none
module tte_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 1365
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: hdl/tte_ctrl.sv
`default_nettype none
module tte_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_in_valid,
    input  wire logic [tte_pkg::MODE_W-1:0]   i_in_mode,
    output logic                              o_in_ready,
    output tte_pkg::t_cmd                     o_cmd,
    input  wire tte_pkg::t_sts                i_sts
);
    import tte_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE) && !i_cfg_we;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cfg_we) begin
                    // new geometry: sweep the tree
                    o_cmd.clr_start = 1'b1;
                    n_state = ST_CLEAR;
                end else if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (t_mode'(i_in_mode))
                        MODE_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state = ST_CLEAR;
                        end
                        MODE_SET, MODE_CODE: begin
                            o_cmd.div_start = 1'b1;
                            n_state = ST_DIV;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (i_sts.in_range) begin
                    o_cmd.path_start = 1'b1;
                    n_state = ST_PATH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PATH: begin
                o_cmd.path_step = 1'b1;
                if (i_sts.path_done) begin
                    if (i_sts.is_code) begin
                        o_cmd.code_begin = 1'b1;
                        n_state = ST_CODE_RD;
                    end else begin
                        o_cmd.set_begin = 1'b1;
                        n_state = ST_SET_RD;
                    end
                end
            end
            ST_SET_RD: begin
                n_state = ST_SET_CMP;
            end
            ST_SET_CMP: begin
                if (i_sts.set_stop) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.set_wr = 1'b1;
                    if (i_sts.lvl_top) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.lvl_up = 1'b1;
                        n_state = ST_SET_RD;
                    end
                end
            end
            ST_CODE_RD: begin
                n_state = ST_CODE_LD;
            end
            ST_CODE_LD: begin
                o_cmd.code_ld = 1'b1;
                n_state = ST_CODE_RUN;
            end
            ST_CODE_RUN: begin
                o_cmd.code_run = 1'b1;
                if (i_sts.run_done) begin
                    n_state = ST_CODE_WR;
                end
            end
            ST_CODE_WR: begin
                o_cmd.code_wr = 1'b1;
                if (i_sts.lvl_zero) begin
                    n_state = ST_FLUSH;
                end else begin
                    o_cmd.lvl_dn = 1'b1;
                    n_state = ST_CODE_RD;
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_sts.flush_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/tte_dp.sv
`default_nettype none
module tte_dp #(
    parameter int MAX_ACROSS    = 32,
    parameter int MAX_DOWN      = 32,
    parameter int MAX_THRESHOLD = 40
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tte_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tte_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic [tte_pkg::MODE_W-1:0]      i_mode,
    input  wire logic [tte_pkg::LEAF_W-1:0]      i_leaf_index,
    input  wire logic [tte_pkg::VALUE_W-1:0]     i_leaf_value,
    input  wire logic [tte_pkg::THR_W-1:0]       i_threshold,
    input  wire tte_pkg::t_cmd                   i_cmd,
    output tte_pkg::t_sts                        o_sts,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_code_bit,
    output logic                                 o_last
);
    import tte_pkg::*;

    localparam int NODE_CAP = tte_node_cap(MAX_ACROSS, MAX_DOWN);
    localparam int NLEV     = tte_levels(MAX_ACROSS, MAX_DOWN);
    localparam int AW       = NODE_CAP > 1 ? $clog2(NODE_CAP) : 1;
    localparam int OW       = $clog2(NODE_CAP + 1);
    localparam int WA       = $clog2(MAX_ACROSS + 1);
    localparam int WD       = $clog2(MAX_DOWN + 1);
    localparam int LW       = NLEV > 1 ? $clog2(NLEV) : 1;
    localparam int LCW      = $clog2(NLEV + 1);

    // configuration
    logic [CFG_W-1:0] r_across;
    logic [CFG_W-1:0] r_down;
    logic [WA-1:0]    w_cl;
    logic [WD-1:0]    h_cl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_across <= CFG_RESET;
            r_down   <= CFG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_W'(0)) begin
                r_across <= i_cfg_data;
            end else begin
                r_down <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (r_across == '0) begin
            w_cl = WA'(1);
        end else if (int'(r_across) > MAX_ACROSS) begin
            w_cl = WA'(MAX_ACROSS);
        end else begin
            w_cl = WA'(r_across);
        end
        if (r_down == '0) begin
            h_cl = WD'(1);
        end else if (int'(r_down) > MAX_DOWN) begin
            h_cl = WD'(MAX_DOWN);
        end else begin
            h_cl = WD'(r_down);
        end
    end

    // item
    logic               r_is_code;
    logic [VALUE_W-1:0] r_v;
    logic [THR_W-1:0]   r_thr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_code <= (t_mode'(i_mode) == MODE_CODE);
            r_v       <= i_leaf_value;
            r_thr     <= (int'(i_threshold) > MAX_THRESHOLD) ? THR_W'(MAX_THRESHOLD)
                                                             : i_threshold;
        end
    end

    // clear sweep
    logic [AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // leaf index divided by grid width, one quotient bit a cycle
    logic [LEAF_W-1:0]    r_quo;
    logic [WA-1:0]        r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [WA:0]          trial;
    logic                 ge;

    assign trial = {r_rem, r_quo[LEAF_W-1]};
    assign ge    = trial >= {1'b0, w_cl};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo     <= i_leaf_index;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= ge ? WA'(trial - {1'b0, w_cl}) : WA'(trial);
            r_quo     <= {r_quo[LEAF_W-2:0], ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    // path of node addresses, leaf first
    logic [WA-1:0]    r_gx;
    logic [WD-1:0]    r_gy;
    logic [WA-1:0]    r_gw;
    logic [WD-1:0]    r_gh;
    logic [OW-1:0]    r_off;
    logic [LCW-1:0]   r_levels;
    logic [AW-1:0]    r_path [NLEV];
    logic [LW-1:0]    r_lvl;
    logic [WA+WD-1:0] n_prod;
    logic [WA+WD-1:0] yw_prod;
    logic [OW-1:0]    node_addr;

    assign n_prod    = WA'(r_gw) * WD'(r_gh);
    assign yw_prod   = r_gy * r_gw;
    assign node_addr = r_off + OW'(yw_prod) + OW'(r_gx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.path_start) begin
            r_gx     <= r_rem;
            r_gy     <= r_quo[WD-1:0];
            r_gw     <= w_cl;
            r_gh     <= h_cl;
            r_off    <= '0;
            r_levels <= '0;
        end else if (i_cmd.path_step) begin
            r_path[r_levels[LW-1:0]] <= AW'(node_addr);
            r_off    <= r_off + OW'(n_prod);
            r_gx     <= r_gx >> 1;
            r_gy     <= r_gy >> 1;
            r_gw     <= WA'(({1'b0, r_gw} + 1'b1) >> 1);
            r_gh     <= WD'(({1'b0, r_gh} + 1'b1) >> 1);
            r_levels <= r_levels + LCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_begin) begin
            r_lvl <= '0;
        end else if (i_cmd.code_begin) begin
            r_lvl <= r_levels[LW-1:0];
        end else if (i_cmd.lvl_up) begin
            r_lvl <= r_lvl + LW'(1);
        end else if (i_cmd.lvl_dn) begin
            r_lvl <= r_lvl - LW'(1);
        end
    end

    // node memory
    t_node         rd_node;
    t_node         wr_node;
    logic [$bits(t_node)-1:0] ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;

    // code walk working registers
    logic [LOW_W-1:0]   r_low;
    logic [VALUE_W-1:0] r_val;
    logic               r_known;

    assign rd_node   = t_node'(ram_rdata);
    assign ram_we    = i_cmd.clr_step || i_cmd.set_wr || i_cmd.code_wr;
    assign ram_waddr = i_cmd.clr_step ? r_clr_cnt : r_path[r_lvl];

    always_comb begin
        if (i_cmd.clr_step) begin
            wr_node = '{value: VALUE_NONE, low: '0, known: 1'b0};
        end else if (i_cmd.set_wr) begin
            wr_node = '{value: r_v, low: rd_node.low, known: rd_node.known};
        end else begin
            wr_node = '{value: r_val, low: r_low, known: r_known};
        end
    end

    tte_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (NODE_CAP)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_node),
        .i_raddr (r_path[r_lvl]),
        .o_rdata (ram_rdata)
    );

    // bit emission: one bit is held back so that last can be marked
    logic r_pend_v;
    logic r_pend_bit;
    logic r_ovalid;
    logic r_obit;
    logic r_olast;
    logic out_free;
    logic can_emit;
    logic lt_thr;
    logic lt_val;
    logic emit0;
    logic emit1;
    logic emit;
    logic push_last;
    logic push;

    assign out_free  = !r_ovalid || i_ready;
    assign can_emit  = !r_pend_v || out_free;
    assign lt_thr    = r_low < r_thr;
    assign lt_val    = VALUE_W'(r_low) < r_val;
    assign emit0     = lt_thr && lt_val;
    assign emit1     = lt_thr && !lt_val && !r_known;
    assign emit      = i_cmd.code_run && (emit0 || emit1) && can_emit;
    assign push_last = i_cmd.flush && r_pend_v && out_free;
    assign push      = (emit && r_pend_v) || push_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.code_begin) begin
            r_low <= '0;
        end else if (i_cmd.code_ld) begin
            r_low   <= (rd_node.low > r_low) ? rd_node.low : r_low;
            r_val   <= rd_node.value;
            r_known <= rd_node.known;
        end else if (emit) begin
            if (emit0) begin
                r_low <= r_low + LOW_W'(1);
            end else begin
                r_known <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_pend_v <= 1'b1;
            end else if (push_last) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pend_bit <= emit1;
        end
        if (push) begin
            r_obit  <= r_pend_bit;
            r_olast <= push_last;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_code_bit = r_obit;
    assign o_last     = r_olast;

    always_comb begin
        o_sts            = '0;
        o_sts.clr_done   = r_clr_cnt == AW'(NODE_CAP - 1);
        o_sts.div_done   = r_div_cnt == DIV_CNT_W'(LEAF_W);
        o_sts.in_range   = r_quo < LEAF_W'(h_cl);
        o_sts.path_done  = (n_prod == (WA+WD)'(1)) || (r_levels == LCW'(NLEV - 1));
        o_sts.is_code    = r_is_code;
        o_sts.set_stop   = rd_node.value <= r_v;
        o_sts.lvl_top    = LCW'(r_lvl) == r_levels - LCW'(1);
        o_sts.lvl_zero   = r_lvl == '0;
        o_sts.run_done   = !lt_thr || (!lt_val && r_known) || (emit1 && can_emit);
        o_sts.flush_done = !r_pend_v || out_free;
    end
endmodule
`default_nettype wire

// File: hdl/tag_tree_encoder.sv
`default_nettype none
// Tag tree encoder: keeps a quad tree of minimum values over a grid of up to
// MAX_ACROSS by MAX_DOWN leaves in one node memory (value, low, known per node)
// and turns code requests into a stream of tag tree bits, one bit per output
// transaction, with last marking the final bit of a request. A clear request,
// a configuration write while idle and reset each start a sweep over the node
// memory, one node a cycle, during which no input transaction is taken. A set
// or code request first divides the leaf index by the grid width, one quotient
// bit a cycle, and checks the row against the grid, then builds
// the leaf-to-root address path, one level a cycle (up to 6 levels at the
// default size). Set then reads and compares each level from the leaf up,
// writing the new value while the stored one is larger; code reads, loads,
// runs and writes back each level from the root down, emitting bits, and then
// hands off the last bit. The node memory has a single read port and a single
// write port. Requests with an unused mode or a leaf outside the grid produce
// nothing. Output stalls hold the walk in place.
module tag_tree_encoder #(
    parameter int MAX_ACROSS    = 32,
    parameter int MAX_DOWN      = 32,
    parameter int MAX_THRESHOLD = 40
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tte_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tte_pkg::CFG_W-1:0]      i_cfg_data,
    tte_in_if.sink                              i_in,
    tte_out_if.source                           o_out
);
    import tte_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller: sequence clear sweep, divide, path build and walks
    tte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // datapath: registers, node memory and output stage
    tte_dp #(
        .MAX_ACROSS    (MAX_ACROSS),
        .MAX_DOWN      (MAX_DOWN),
        .MAX_THRESHOLD (MAX_THRESHOLD)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_in.mode),
        .i_leaf_index (i_in.leaf_index),
        .i_leaf_value (i_in.leaf_value),
        .i_threshold  (i_in.threshold),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_code_bit   (o_out.code_bit),
        .o_last       (o_out.last)
    );
endmodule
`default_nettype wire
